@@ rtl/core/tpf_pkg.sv @@
package tpf_pkg;

    // field and register widths
    localparam int TIME_W      = 32;
    localparam int VALUE_W     = 32;
    localparam int REL_W       = 16;
    localparam int GAP_W       = 32;
    localparam int PROD_W      = REL_W + VALUE_W;
    localparam int TDATA_W     = TIME_W + VALUE_W;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 32;

    // window geometry: three stored points, four once the new one is appended
    localparam int WIN_DEPTH    = 3;
    localparam int APP_DEPTH    = WIN_DEPTH + 1;
    localparam int FILL_W       = $clog2(APP_DEPTH);
    localparam int CNT_W        = $clog2(APP_DEPTH + 1);
    localparam int BUNDLE_DEPTH = 4;
    localparam int BIDX_W       = $clog2(BUNDLE_DEPTH);

    localparam logic [CNT_W-1:0] SEEN_MAX = CNT_W'(4);

    // register map
    localparam logic [CFG_IDX_W-1:0] CFG_REL = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_GAP = CFG_IDX_W'(1);

    localparam logic [REL_W-1:0] REL_RESET = REL_W'(3277);
    localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(3600);

    // one window point; p caches rel_threshold * v
    typedef struct packed {
        logic [TIME_W-1:0]  t;
        logic [VALUE_W-1:0] v;
        logic [PROD_W-1:0]  p;
    } tpf_point_t;

    typedef struct packed {
        tpf_point_t pt;
        logic       last;
    } tpf_item_t;

    typedef struct packed {
        logic [TIME_W-1:0]  t;
        logic [VALUE_W-1:0] v;
        logic               last;
    } tpf_result_t;

    // all results caused by one input word
    typedef struct packed {
        tpf_result_t [BUNDLE_DEPTH-1:0] res;
        logic [CNT_W-1:0]               cnt;
    } tpf_bundle_t;

    // pairwise flags over the appended window, symmetric where it matters
    typedef logic [APP_DEPTH-1:0][APP_DEPTH-1:0] tpf_pmat_t;

    // current window as slots into the appended window
    typedef struct packed {
        logic [APP_DEPTH-1:0][FILL_W-1:0] idx;
        logic [CNT_W-1:0]                 cnt;
    } tpf_view_t;

    typedef struct packed {
        tpf_view_t             view;
        logic                  tail;
        logic [1:0]            ecnt;
        logic [2:0][FILL_W-1:0] eidx;
    } tpf_iter_t;

    // one pass of the unit decision over a three or four point view
    function automatic tpf_iter_t tpf_iter(
        tpf_view_t v,
        logic      tail,
        logic      last,
        logic      en,
        tpf_pmat_t lg,
        tpf_pmat_t gp,
        tpf_pmat_t gt
    );
        logic [FILL_W-1:0] i0, i1, i2, i3;
        logic l1, l2, g1, g2, four, run, u2, trend_b, trend_d;
        tpf_iter_t r;
        i0 = v.idx[0];
        i1 = v.idx[1];
        i2 = v.idx[2];
        i3 = v.idx[3];
        l1 = lg[i0][i1];
        l2 = lg[i1][i2];
        g1 = gp[i0][i1];
        g2 = gp[i1][i2];
        four = (v.cnt == CNT_W'(4));
        run  = en && (four || v.cnt == CNT_W'(3));
        u2   = last && tail && !four;
        // both steps point the same way
        trend_b = (gt[i3][i1] && gt[i1][i0]) || (gt[i1][i3] && gt[i0][i1]);
        trend_d = (gt[i2][i0] && gt[i1][i0]) || (gt[i0][i2] && gt[i0][i1]);

        r         = '0;
        r.view    = v;
        r.tail    = tail;
        r.ecnt    = 2'd0;
        r.eidx[0] = i0;
        r.eidx[1] = i1;
        r.eidx[2] = i2;

        if (run) begin
            if ((l1 && l2) || (l1 && !l2 && g2) || (!l1 && l2 && g1)) begin
                // keep the first two
                r.ecnt        = 2'd2;
                r.view.idx[0] = i2;
                r.view.idx[1] = i3;
                r.view.cnt    = v.cnt - CNT_W'(2);
            end else if (l1 && !l2) begin
                // large then small, needs the lookahead point
                if (!four) begin
                    if (u2) begin
                        r.ecnt     = 2'd3;
                        r.view.cnt = '0;
                    end
                end else if (last) begin
                    r.ecnt     = 2'd3;
                    r.eidx[2]  = i3;
                    r.view.cnt = '0;
                end else if (trend_b) begin
                    r.view.idx[1] = i3;
                    r.view.cnt    = CNT_W'(2);
                end else begin
                    r.view.cnt = CNT_W'(2);
                    r.tail     = 1'b0;
                end
            end else if (!l1 && l2) begin
                // small then large, drop the first two
                r.view.idx[0] = i2;
                r.view.idx[1] = i3;
                r.view.cnt    = v.cnt - CNT_W'(2);
            end else begin
                // small then small
                if (u2) begin
                    r.ecnt     = 2'd3;
                    r.view.cnt = '0;
                end else if (g1 || g2) begin
                    r.view.idx[1] = i2;
                    r.view.idx[2] = i3;
                    r.view.cnt    = v.cnt - CNT_W'(1);
                end else if (trend_d) begin
                    if (!four) begin
                        r.tail = 1'b0;
                    end
                    r.view.idx[1] = i3;
                    r.view.cnt    = v.cnt - CNT_W'(2);
                end else begin
                    r.view.idx[0] = i2;
                    r.view.idx[1] = i3;
                    r.view.cnt    = v.cnt - CNT_W'(2);
                end
            end
        end
        return r;
    endfunction

endpackage

@@ rtl/core/tpf_window.sv @@
module tpf_window (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           item_valid,
    input  tpf_pkg::tpf_item_t             item,
    input  logic [tpf_pkg::REL_W-1:0]      rel_threshold,
    input  logic [tpf_pkg::GAP_W-1:0]      gap_threshold,
    input  logic                           refresh,
    input  logic                           bundle_free,
    output logic                           take,
    output tpf_pkg::tpf_bundle_t           bundle
);
    import tpf_pkg::*;

    tpf_point_t        win_reg [WIN_DEPTH];
    logic [FILL_W-1:0] fill_reg;
    logic [CNT_W-1:0]  seen_reg;
    logic              head_reg;

    tpf_point_t        app [APP_DEPTH];
    tpf_pmat_t         lg, gp, gt;
    logic [CNT_W-1:0]  app_cnt;
    logic [CNT_W-1:0]  seen_inc;
    logic              headfire;
    logic              quiet;
    tpf_view_t         view0;
    tpf_iter_t         r1, r2;
    tpf_view_t         fv;

    // stored points followed by the new word
    always_comb begin
        for (int k = 0; k < WIN_DEPTH; k++) begin
            app[k] = (fill_reg == FILL_W'(k)) ? item.pt : win_reg[k];
        end
        app[APP_DEPTH-1] = item.pt;
    end

    // large step, time gap and ordering for every pair
    always_comb begin
        logic [VALUE_W-1:0] dv;
        logic [TIME_W-1:0]  dt;
        logic [PROD_W:0]    lhs;
        logic [PROD_W:0]    rhs;
        lg  = '0;
        gp  = '0;
        gt  = '0;
        dv  = '0;
        dt  = '0;
        lhs = '0;
        rhs = '0;
        for (int i = 0; i < APP_DEPTH; i++) begin
            for (int j = i + 1; j < APP_DEPTH; j++) begin
                dv = (app[i].v > app[j].v) ? app[i].v - app[j].v : app[j].v - app[i].v;
                dt = (app[i].t > app[j].t) ? app[i].t - app[j].t : app[j].t - app[i].t;
                lhs = {1'b0, dv, {REL_W{1'b0}}};
                rhs = {1'b0, app[i].p} + {1'b0, app[j].p};
                lg[i][j] = (lhs > rhs);
                lg[j][i] = (lhs > rhs);
                gp[i][j] = (dt > gap_threshold);
                gp[j][i] = (dt > gap_threshold);
                gt[i][j] = (app[i].v > app[j].v);
                gt[j][i] = (app[j].v > app[i].v);
            end
        end
    end

    // head handling and up to two unit decisions
    always_comb begin
        app_cnt  = {1'b0, fill_reg} + CNT_W'(1);
        seen_inc = (seen_reg == SEEN_MAX) ? seen_reg : seen_reg + CNT_W'(1);
        headfire = !head_reg && (seen_inc == SEEN_MAX);
        quiet    = !head_reg && (seen_inc != SEEN_MAX);
        if (headfire) begin
            view0.idx = {FILL_W'(3), FILL_W'(3), FILL_W'(2), FILL_W'(1)};
            view0.cnt = CNT_W'(3);
        end else begin
            view0.idx = {FILL_W'(3), FILL_W'(2), FILL_W'(1), FILL_W'(0)};
            view0.cnt = app_cnt;
        end
        r1 = tpf_iter(view0, 1'b1, item.last, !quiet, lg, gp, gt);
        r2 = tpf_iter(r1.view, r1.tail, item.last, !quiet, lg, gp, gt);
        fv = r2.view;
    end

    // pack the results of this word in order
    always_comb begin
        logic [CNT_W-1:0] pos;
        bundle = '0;
        pos    = '0;
        if (headfire) begin
            bundle.res[pos[BIDX_W-1:0]].t = app[0].t;
            bundle.res[pos[BIDX_W-1:0]].v = app[0].v;
            pos = pos + CNT_W'(1);
        end
        for (int j = 0; j < 3; j++) begin
            if (2'(j) < r1.ecnt) begin
                bundle.res[pos[BIDX_W-1:0]].t = app[r1.eidx[j]].t;
                bundle.res[pos[BIDX_W-1:0]].v = app[r1.eidx[j]].v;
                pos = pos + CNT_W'(1);
            end
        end
        for (int j = 0; j < 3; j++) begin
            if (2'(j) < r2.ecnt) begin
                bundle.res[pos[BIDX_W-1:0]].t = app[r2.eidx[j]].t;
                bundle.res[pos[BIDX_W-1:0]].v = app[r2.eidx[j]].v;
                pos = pos + CNT_W'(1);
            end
        end
        // end of series flushes what is left
        if (item.last && !quiet) begin
            for (int j = 0; j < 3; j++) begin
                if (CNT_W'(j) < fv.cnt) begin
                    bundle.res[pos[BIDX_W-1:0]].t = app[fv.idx[j]].t;
                    bundle.res[pos[BIDX_W-1:0]].v = app[fv.idx[j]].v;
                    pos = pos + CNT_W'(1);
                end
            end
        end
        if (item.last && pos != '0) begin
            bundle.res[pos[BIDX_W-1:0] - BIDX_W'(1)].last = 1'b1;
        end
        bundle.cnt = pos;
    end

    // a word with no results does not need the bundle register
    assign take = item_valid && !refresh && (bundle_free || bundle.cnt == '0);

    // series control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            seen_reg <= '0;
            head_reg <= 1'b0;
        end else if (take) begin
            if (item.last) begin
                fill_reg <= '0;
                seen_reg <= '0;
                head_reg <= 1'b0;
            end else begin
                fill_reg <= fv.cnt[FILL_W-1:0];
                seen_reg <= seen_inc;
                head_reg <= head_reg | headfire;
            end
        end
    end

    // window payload, products redone after a threshold write
    always_ff @(posedge aclk) begin
        if (refresh) begin
            for (int k = 0; k < WIN_DEPTH; k++) begin
                win_reg[k].p <= PROD_W'(rel_threshold) * PROD_W'(win_reg[k].v);
            end
        end else if (take) begin
            for (int k = 0; k < WIN_DEPTH; k++) begin
                win_reg[k] <= app[fv.idx[k]];
            end
        end
    end

endmodule

@@ rtl/core/turning_point_filter_unit.sv @@
// Turning point filter: reduces a stream of (time, value) samples to its
// turning points.
// Input words arrive on s_tvalid/s_tready/s_tdata with s_tlast closing a
// series; kept points leave on m_tvalid/m_tready/m_tdata, m_tlast on the
// last kept point. The first and last points of a series of four or more
// points are always kept, a series of fewer than four points yields nothing.
// Configuration: cfg_index 0 writes the relative threshold (fraction of
// 65536), index 1 the time gap threshold; other indexes are ignored. Write
// only while the block is idle. After a relative threshold write the cached
// window products are recomputed in the cycle after the write, during which
// no word moves from the input register into the window.
// Results pass the input register, bundle register and output register in turn.
// Throughput: one input word per cycle unless a refresh runs or the bundle
// register is busy; a word with n results holds the single bundle register
// until all n drain, so the output port sets the rate when n is above one.
// Reset clears the series state, the thresholds go to 3277 and 3600.
// When the receiver stalls, results wait in the output register and the
// bundle register, then s_tready drops; nothing is lost.
module turning_point_filter_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tpf_pkg::TDATA_W-1:0]       s_tdata,   // in_time, in_value
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tpf_pkg::TDATA_W-1:0]       m_tdata,   // out_time, out_value
    output logic                              m_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tpf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tpf_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import tpf_pkg::*;

    logic [REL_W-1:0]  rel_reg;
    logic [GAP_W-1:0]  gap_reg;
    logic              refresh_reg;
    logic              cfg_wr;

    logic              in_valid_reg;
    tpf_item_t         in_item_reg;
    tpf_item_t         in_item_next;

    logic              take;
    logic              bundle_free;
    tpf_bundle_t       bundle_next;

    tpf_result_t [BUNDLE_DEPTH-1:0] bun_res_reg;
    logic [CNT_W-1:0]  bun_cnt_reg;
    logic [BIDX_W-1:0] bun_rd_reg;
    logic              bun_drain;
    logic              m_load;

    logic              m_valid_reg;
    tpf_result_t       m_word_reg;

    // configuration registers
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rel_reg     <= REL_RESET;
            gap_reg     <= GAP_RESET;
            refresh_reg <= 1'b0;
        end else begin
            refresh_reg <= cfg_wr && (cfg_index == CFG_REL);
            if (cfg_wr && cfg_index == CFG_REL) begin
                rel_reg <= cfg_data[REL_W-1:0];
            end
            if (cfg_wr && cfg_index == CFG_GAP) begin
                gap_reg <= cfg_data[GAP_W-1:0];
            end
        end
    end

    // input register, threshold product taken on the way in
    assign s_tready = !in_valid_reg || take;

    always_comb begin
        in_item_next.pt.t = s_tdata[TIME_W-1:0];
        in_item_next.pt.v = s_tdata[TIME_W +: VALUE_W];
        in_item_next.pt.p = PROD_W'(rel_reg) * PROD_W'(s_tdata[TIME_W +: VALUE_W]);
        in_item_next.last = s_tlast;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= in_item_next;
        end
    end

    // window and decision logic
    tpf_window u_window (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item_valid    (in_valid_reg),
        .item          (in_item_reg),
        .rel_threshold (rel_reg),
        .gap_threshold (gap_reg),
        .refresh       (refresh_reg),
        .bundle_free   (bundle_free),
        .take          (take),
        .bundle        (bundle_next)
    );

    // bundle register drains one word per cycle into the output register unless the output stalls
    assign m_load      = (bun_cnt_reg != '0) && (!m_valid_reg || m_tready);
    assign bun_drain   = m_load && ((CNT_W'(bun_rd_reg) + CNT_W'(1)) == bun_cnt_reg);
    assign bundle_free = (bun_cnt_reg == '0) || bun_drain;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bun_cnt_reg <= '0;
            bun_rd_reg  <= '0;
        end else if (take && bundle_next.cnt != '0) begin
            bun_cnt_reg <= bundle_next.cnt;
            bun_rd_reg  <= '0;
        end else if (bun_drain) begin
            bun_cnt_reg <= '0;
        end else if (m_load) begin
            bun_rd_reg <= bun_rd_reg + BIDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (take && bundle_next.cnt != '0) begin
            bun_res_reg <= bundle_next.res;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (m_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_load) begin
            m_word_reg <= bun_res_reg[bun_rd_reg];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_word_reg.v, m_word_reg.t};
    assign m_tlast  = m_word_reg.last;

endmodule
